[rtl/core/nonpreemptive_batch_scheduler_top_defines.svh]
// ----------------------------------------------------------------------------
// nonpreemptive_batch_scheduler_top_defines.svh
// Assertion macros for the batch scheduler; empty bodies under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef NONPREEMPTIVE_BATCH_SCHEDULER_TOP_DEFINES_SVH
`define NONPREEMPTIVE_BATCH_SCHEDULER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a condition on every clock edge outside reset
`define NBS_ASSERT_NOW(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Check that a condition implies another on the next clock edge
`define NBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define NBS_ASSERT_NOW(lbl, expr, msg)
`define NBS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/core/nbs_pkg.sv]
// ----------------------------------------------------------------------------
// nbs_pkg
// Shared sizes, policy codes and payload types of the batch scheduler.
// ----------------------------------------------------------------------------
package nbs_pkg;

  // Table size and derived widths
  localparam int MAX_JOBS = 32;
  localparam int IDX_W    = $clog2(MAX_JOBS);
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);

  // Field widths
  localparam int ID_W     = 8;
  localparam int BURST_W  = 16;
  localparam int PRIO_W   = 8;
  localparam int TIME_W   = 21;
  localparam int ACC_W    = 22;
  localparam int POL_W    = 2;

  // Scheduling policies (other codes behave as arrival order)
  localparam logic [POL_W-1:0] POL_FIFO = 2'd0;
  localparam logic [POL_W-1:0] POL_SJF  = 2'd1;
  localparam logic [POL_W-1:0] POL_PRIO = 2'd2;

  // One table entry, also the packed input payload (id in the low bits)
  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
    logic [ID_W-1:0]    id;
  } job_entry_t;

  // One schedule result
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] finish;
    logic              ovf;
    logic              last;
  } result_t;

endpackage

[rtl/core/nonpreemptive_batch_scheduler_top.sv]
// ----------------------------------------------------------------------------
// nonpreemptive_batch_scheduler_top
// Non-preemptive batch scheduler: arrival order, shortest burst or priority.
// ----------------------------------------------------------------------------
// Jobs are loaded one per input transfer into a table of MAX_JOBS (32)
// entries; jobs beyond that are dropped and every result of the batch then
// carries the overflow flag. The transfer with tlast set starts the schedule,
// and input is held off until the last result of the batch has been produced.
// For each result the selection reads every loaded entry through the single
// read port of the job memory, one entry per cycle, then drains the last read
// and emits; the emit state waits while the output register still holds an
// untaken result. Results run back to back from time zero in run order; ties
// go to the earlier-loaded job and policy code 3 acts as arrival order.
// Policy writes are meant for idle periods only.
// ----------------------------------------------------------------------------
`include "nonpreemptive_batch_scheduler_top_defines.svh"

module nonpreemptive_batch_scheduler_top (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration
  input  logic                      cfg_we,
  input  logic [nbs_pkg::POL_W-1:0] cfg_wdata,   // policy
  // job input
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [31:0]               in_tdata,   // job_id, burst, priority_req
  input  logic                      in_tlast,   // last_job
  // schedule results
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [55:0]               out_tdata,  // sched_id, start_time, finish_time
  output logic                      out_tuser,  // overflowed
  output logic                      out_tlast   // last_result
);

  logic [nbs_pkg::POL_W-1:0] policy_r;
  logic                      out_vld_r, out_vld_nxt;
  nbs_pkg::result_t          out_r;
  logic                      out_free;
  logic                      res_vld;
  nbs_pkg::result_t          res;

  logic                      ram_we;
  logic [nbs_pkg::IDX_W-1:0] ram_waddr;
  nbs_pkg::job_entry_t       ram_wdata;
  logic                      ram_re;
  logic [nbs_pkg::IDX_W-1:0] ram_raddr;
  nbs_pkg::job_entry_t       ram_rdata;

  // Policy register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= nbs_pkg::POL_SJF;
    end else if (cfg_we) begin
      policy_r <= cfg_wdata;
    end
  end

  nbs_job_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nbs_sched_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_job    (nbs_pkg::job_entry_t'(in_tdata)),
    .in_last   (in_tlast),
    .in_ready  (in_tready),
    .policy    (policy_r),
    .out_free  (out_free),
    .res_vld   (res_vld),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Output register: load a new result, drop it after its transfer
  assign out_free = !out_vld_r || out_tready;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (res_vld) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, out_r.finish, out_r.start, out_r.id};
  assign out_tuser  = out_r.ovf;
  assign out_tlast  = out_r.last;

  // Assertions
  `NBS_ASSERT_NOW(a_res_slot_free, !res_vld || !out_vld_r || out_tready, "result slot busy")
  `NBS_ASSERT_NOW(a_load_excl_emit, !(in_tready && res_vld), "load and emit overlapped")
  `NBS_ASSERT_NEXT(a_busy_mid_batch, res_vld && !res.last, !in_tready, "input reopened early")

endmodule

[rtl/core/nbs_job_ram.sv]
// ----------------------------------------------------------------------------
// nbs_job_ram
// Job table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module nbs_job_ram (
  input  logic                     clk,
  input  logic                     we,
  input  logic [nbs_pkg::IDX_W-1:0] waddr,
  input  nbs_pkg::job_entry_t      wdata,
  input  logic                     re,
  input  logic [nbs_pkg::IDX_W-1:0] raddr,
  output nbs_pkg::job_entry_t      rdata
);

  nbs_pkg::job_entry_t mem [nbs_pkg::MAX_JOBS];

  // Write a loaded job
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one entry, data valid the next cycle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/nbs_sched_ctrl.sv]
// ----------------------------------------------------------------------------
// nbs_sched_ctrl
// Load sequencer, selection scan over the job table and result generation.
// ----------------------------------------------------------------------------
module nbs_sched_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  // load side
  input  logic                            in_valid,
  input  nbs_pkg::job_entry_t             in_job,
  input  logic                            in_last,
  output logic                            in_ready,
  // configuration
  input  logic [nbs_pkg::POL_W-1:0]       policy,
  // result side
  input  logic                            out_free,
  output logic                            res_vld,
  output nbs_pkg::result_t                res,
  // job table
  output logic                            ram_we,
  output logic [nbs_pkg::IDX_W-1:0]       ram_waddr,
  output nbs_pkg::job_entry_t             ram_wdata,
  output logic                            ram_re,
  output logic [nbs_pkg::IDX_W-1:0]       ram_raddr,
  input  nbs_pkg::job_entry_t             ram_rdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                          state_r,  state_nxt;
  logic [nbs_pkg::CNT_W-1:0]           count_r,  count_nxt;
  logic [nbs_pkg::CNT_W-1:0]           scan_r,   scan_nxt;
  logic [nbs_pkg::CNT_W-1:0]           rcnt_r,   rcnt_nxt;
  logic                                drop_r,   drop_nxt;
  logic [nbs_pkg::ACC_W-1:0]           acc_r,    acc_nxt;
  logic [nbs_pkg::MAX_JOBS-1:0]        done_r,   done_nxt;
  logic                                pend_r,   pend_nxt;
  logic [nbs_pkg::IDX_W-1:0]           pidx_r,   pidx_nxt;
  logic                                have_r,   have_nxt;
  logic [nbs_pkg::IDX_W-1:0]           bidx_r,   bidx_nxt;
  nbs_pkg::job_entry_t                 best_r,   best_nxt;

  logic                                load;
  logic                                full;
  logic                                issue;
  logic                                better;
  logic                                last_res;
  logic [nbs_pkg::ACC_W-1:0]           acc_sum;

  assign full     = (count_r == nbs_pkg::CNT_W'(nbs_pkg::MAX_JOBS));
  assign in_ready = (state_r == ST_IDLE);
  assign load     = in_valid && in_ready;
  assign issue    = (state_r == ST_SCAN) && (scan_r < count_r);
  assign last_res = ((rcnt_r + nbs_pkg::CNT_W'(1)) == count_r);
  assign acc_sum  = acc_r + nbs_pkg::ACC_W'(best_r.burst);

  // Table ports
  assign ram_we    = load && !full;
  assign ram_waddr = count_r[nbs_pkg::IDX_W-1:0];
  assign ram_wdata = in_job;
  assign ram_re    = issue;
  assign ram_raddr = scan_r[nbs_pkg::IDX_W-1:0];

  // Compare the returned entry against the current best
  always_comb begin
    case (policy)
      nbs_pkg::POL_SJF:  better = (ram_rdata.burst < best_r.burst);
      nbs_pkg::POL_PRIO: better = (ram_rdata.prio < best_r.prio);
      default:           better = 1'b0;
    endcase
  end

  // Result payload
  assign res_vld     = (state_r == ST_EMIT) && out_free;
  assign res.id      = best_r.id;
  assign res.start   = acc_r[nbs_pkg::TIME_W-1:0];
  assign res.finish  = acc_sum[nbs_pkg::TIME_W-1:0];
  assign res.ovf     = drop_r;
  assign res.last    = last_res;

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    scan_nxt  = scan_r;
    rcnt_nxt  = rcnt_r;
    drop_nxt  = drop_r;
    acc_nxt   = acc_r;
    done_nxt  = done_r;
    pend_nxt  = 1'b0;
    pidx_nxt  = scan_r[nbs_pkg::IDX_W-1:0];
    have_nxt  = have_r;
    bidx_nxt  = bidx_r;
    best_nxt  = best_r;
    case (state_r)
      ST_IDLE: begin
        if (load) begin
          if (full) begin
            drop_nxt = 1'b1;
          end else begin
            count_nxt = count_r + nbs_pkg::CNT_W'(1);
          end
          if (in_last) begin
            state_nxt = ST_SCAN;
            scan_nxt  = '0;
            rcnt_nxt  = '0;
            acc_nxt   = '0;
            have_nxt  = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        // issue the next read, evaluate the previous one
        if (issue) begin
          scan_nxt = scan_r + nbs_pkg::CNT_W'(1);
          pend_nxt = 1'b1;
        end
        if (pend_r && !done_r[pidx_r] && (!have_r || better)) begin
          have_nxt = 1'b1;
          bidx_nxt = pidx_r;
          best_nxt = ram_rdata;
        end
        if (!issue) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          acc_nxt          = acc_sum;
          done_nxt[bidx_r] = 1'b1;
          rcnt_nxt         = rcnt_r + nbs_pkg::CNT_W'(1);
          if (last_res) begin
            // empty the table for the next batch
            state_nxt = ST_IDLE;
            done_nxt  = '0;
            count_nxt = '0;
            drop_nxt  = 1'b0;
            acc_nxt   = '0;
          end else begin
            state_nxt = ST_SCAN;
            scan_nxt  = '0;
            have_nxt  = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      scan_r  <= '0;
      rcnt_r  <= '0;
      drop_r  <= 1'b0;
      acc_r   <= '0;
      done_r  <= '0;
      pend_r  <= 1'b0;
      have_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      scan_r  <= scan_nxt;
      rcnt_r  <= rcnt_nxt;
      drop_r  <= drop_nxt;
      acc_r   <= acc_nxt;
      done_r  <= done_nxt;
      pend_r  <= pend_nxt;
      have_r  <= have_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pidx_r <= pidx_nxt;
    bidx_r <= bidx_nxt;
    best_r <= best_nxt;
  end

endmodule

[dv/nonpreemptive_batch_scheduler_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Batch scheduler checker
// Watches the job, result and policy ports of the scheduler. It keeps its own
// job table and, on each batch-closing transfer, plans the run order under the
// current policy. Results are compared in order with that plan.
// ----------------------------------------------------------------------------
module sched_checker
  import nbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [POL_W-1:0] cfg_wdata,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [31:0]      s_tdata,   // job_id, burst, priority_req
  input  logic             s_tlast,   // last_job
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [55:0]      m_tdata,   // sched_id, start_time, finish_time
  input  logic             m_tuser,   // overflowed
  input  logic             m_tlast,   // last_result
  output int               fail_count,
  output int               open_results
);

  job_entry_t       job_table [MAX_JOBS];
  bit               run_done  [MAX_JOBS];
  int unsigned      jobs_held;
  bit               jobs_dropped;
  logic [POL_W-1:0] policy_q;
  result_t          pending_runs [$];

  // Select the next job still waiting; MAX_JOBS when none is left
  function automatic int unsigned pick_next_job();
    int unsigned best;
    best = MAX_JOBS;
    for (int unsigned k = 0; k < jobs_held; k++) begin
      if (run_done[k]) continue;
      if (best == MAX_JOBS) begin
        best = k;
        if (policy_q != POL_SJF && policy_q != POL_PRIO) break;
      end else if (policy_q == POL_SJF && job_table[k].burst < job_table[best].burst) begin
        best = k;
      end else if (policy_q == POL_PRIO && job_table[k].prio < job_table[best].prio) begin
        best = k;
      end
    end
    return best;
  endfunction

  // Run the loaded jobs back to back from time zero, then empty the table
  task automatic plan_schedule();
    logic [ACC_W-1:0] clock_acc;
    int unsigned      pick;
    result_t          run;
    clock_acc = '0;
    for (int unsigned r = 0; r < jobs_held; r++) begin
      pick = pick_next_job();
      if (pick >= MAX_JOBS) break;
      run_done[pick] = 1'b1;
      run.id     = job_table[pick].id;
      run.start  = clock_acc[TIME_W-1:0];
      clock_acc  = clock_acc + job_table[pick].burst;
      run.finish = clock_acc[TIME_W-1:0];
      run.ovf    = jobs_dropped;
      run.last   = (r + 1 == jobs_held);
      pending_runs.push_back(run);
    end
    foreach (run_done[i]) run_done[i] = 1'b0;
    jobs_held    = 0;
    jobs_dropped = 1'b0;
  endtask

  // Compare one result transfer with the oldest planned run
  task automatic check_run(input result_t got);
    result_t want;
    if (pending_runs.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("ERROR: unexpected result id=%0d start=%0d finish=%0d ovf=%0b last=%0b",
                 got.id, got.start, got.finish, got.ovf, got.last);
    end else begin
      want = pending_runs.pop_front();
      if (got.id !== want.id || got.start !== want.start || got.finish !== want.finish ||
          got.ovf !== want.ovf || got.last !== want.last) begin
        fail_count++;
        if (fail_count <= 10)
          $display({"ERROR: result mismatch: ",
                    "expected id=%0d start=%0d finish=%0d ovf=%0b last=%0b, ",
                    "got id=%0d start=%0d finish=%0d ovf=%0b last=%0b"},
                   want.id, want.start, want.finish, want.ovf, want.last,
                   got.id, got.start, got.finish, got.ovf, got.last);
      end
    end
  endtask

  // Track policy writes, job loads and result transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (run_done[i]) run_done[i] = 1'b0;
      jobs_held    = 0;
      jobs_dropped = 1'b0;
      policy_q     = POL_SJF;
      fail_count   = 0;
      pending_runs.delete();
    end else begin
      if (cfg_we) policy_q = cfg_wdata;
      if (m_tvalid && m_tready)
        check_run({m_tdata[7:0], m_tdata[28:8], m_tdata[49:29], m_tuser, m_tlast});
      if (s_tvalid && s_tready) begin
        if (jobs_held < MAX_JOBS) begin
          job_table[jobs_held] = s_tdata;
          jobs_held++;
        end else begin
          jobs_dropped = 1'b1;
        end
        if (s_tlast) plan_schedule();
      end
    end
    open_results = pending_runs.size();
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Batch scheduler testbench
// Loads job batches into the scheduler under every policy: a short directed
// set of extreme and tied jobs, then random batches of mixed sizes, some of
// them filling or overrunning the job table. Both stream sides idle at random.
// The checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import nbs_pkg::*;

  localparam int               ITEM_TARGET   = 270;
  localparam int               SETTLE_CYCLES = MAX_JOBS + 8;
  localparam logic [POL_W-1:0] POL_SPARE     = 2'd3;   // unused code, acts as arrival order

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [POL_W-1:0] cfg_wdata;
  logic             s_tvalid;
  logic             s_tready;
  logic [31:0]      s_tdata;
  logic             s_tlast;
  logic             m_tvalid;
  logic             m_tready;
  logic [55:0]      m_tdata;
  logic             m_tuser;
  logic             m_tlast;
  int               fail_count;
  int               open_results;
  int unsigned      jobs_sent;
  bit               steady_feed;

  nonpreemptive_batch_scheduler_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (s_tvalid),
    .in_tready  (s_tready),
    .in_tdata   (s_tdata),
    .in_tlast   (s_tlast),
    .out_tvalid (m_tvalid),
    .out_tready (m_tready),
    .out_tdata  (m_tdata),
    .out_tuser  (m_tuser),
    .out_tlast  (m_tlast)
  );

  sched_checker schedule_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast),
    .fail_count   (fail_count),
    .open_results (open_results)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop for a hung run
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: ready stretches with short stalls and a few long ones
  initial begin
    int unsigned hold;
    int unsigned roll;
    m_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      roll = $urandom_range(0, 99);
      hold = (roll < 85) ? $urandom_range(1, 8) : $urandom_range(100, 300);
      m_tready <= 1'b1;
      repeat (hold) @(posedge clk);
      roll = $urandom_range(0, 99);
      if (roll < 60)      hold = $urandom_range(1, 3);
      else if (roll < 90) hold = $urandom_range(4, 10);
      else                hold = $urandom_range(20, 60);
      m_tready <= 1'b0;
      repeat (hold) @(posedge clk);
    end
  end

  // Idle cycles ahead of a job transfer: mostly none or short, rarely long
  function automatic int unsigned feed_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady_feed || roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one job and hold it until the transfer completes
  task automatic push_job(input logic [ID_W-1:0] id, input logic [BURST_W-1:0] burst,
                          input logic [PRIO_W-1:0] prio, input bit last_flag);
    int unsigned gap;
    job_entry_t  job;
    gap       = feed_gap();
    job.id    = id;
    job.burst = burst;
    job.prio  = prio;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= job;
    s_tlast  <= last_flag;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    jobs_sent++;
  endtask

  // Change the policy once the previous batch has fully drained
  task automatic set_policy(input logic [POL_W-1:0] pol);
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (open_results == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= pol;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Extreme fields plus a tied pair on both burst and priority
  task automatic probe_batch();
    push_job(8'h00, 16'hFFFF, 8'hFF, 1'b0);
    push_job(8'hFF, 16'h0000, 8'h00, 1'b0);
    push_job(8'h5A, 16'd100,  8'd7,  1'b0);
    push_job(8'hA5, 16'd100,  8'd7,  1'b0);
    push_job(8'h01, 16'hFFFF, 8'h00, 1'b1);
  endtask

  // One random batch; the content style steers toward ties or extremes
  task automatic run_batch(input int unsigned n_jobs, input int unsigned style);
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    for (int unsigned i = 0; i < n_jobs; i++) begin
      case (style)
        0: begin
          burst = BURST_W'($urandom_range(0, 65535));
          prio  = PRIO_W'($urandom_range(0, 255));
        end
        1: begin
          burst = BURST_W'($urandom_range(0, 7));
          prio  = PRIO_W'($urandom_range(0, 3));
        end
        2: begin
          burst = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          prio  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          if ($urandom_range(0, 3) == 0) burst = BURST_W'($urandom_range(0, 65535));
        end
        default: begin
          burst = 16'hFFFF;
          prio  = PRIO_W'($urandom_range(0, 255));
        end
      endcase
      push_job(ID_W'($urandom_range(0, 255)), burst, prio, i == n_jobs - 1);
    end
  endtask

  // Stimulus and verdict
  initial begin
    int unsigned batch_no;
    int unsigned n_jobs;
    int unsigned style;
    int unsigned roll;
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= POL_SJF;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tlast     <= 1'b0;
    jobs_sent   = 0;
    steady_feed = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: the probe batch under each policy, then a lone zero-length job
    probe_batch();
    set_policy(POL_FIFO);
    probe_batch();
    set_policy(POL_PRIO);
    probe_batch();
    set_policy(POL_SPARE);
    probe_batch();
    push_job(8'h7E, 16'h0000, 8'h80, 1'b1);

    // Random batches; the first one fills the table with the longest jobs and
    // overruns it, with the closing mark on a dropped job
    batch_no = 0;
    while (jobs_sent < ITEM_TARGET) begin
      if (batch_no == 0) begin
        n_jobs = MAX_JOBS + 2;
        style  = 3;
      end else begin
        roll = $urandom_range(0, 11);
        if (roll == 0)     n_jobs = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 8);
        else if (roll == 1) n_jobs = MAX_JOBS;
        else if (roll < 4) n_jobs = $urandom_range(9, MAX_JOBS - 1);
        else               n_jobs = $urandom_range(1, 8);
        style = $urandom_range(0, 3);
      end
      if ($urandom_range(0, 2) == 0) set_policy(POL_W'($urandom_range(0, 3)));
      steady_feed = ($urandom_range(0, 3) == 0);
      run_batch(n_jobs, style);
      batch_no++;
    end
    s_tvalid <= 1'b0;

    // Drain, then allow a quiet stretch for any stray result
    @(posedge clk);
    wait (open_results == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && open_results == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/nbs_pkg.sv
rtl/core/nbs_job_ram.sv
rtl/core/nbs_sched_ctrl.sv
rtl/core/nonpreemptive_batch_scheduler_top.sv
dv/nonpreemptive_batch_scheduler_checker.sv
dv/testbench.sv
